// ===== src/tmcg_pkg.sv =====
package tmcg_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int TRIG_BITS    = 16;

    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int REM_W   = $clog2(MAX_SEGMENTS);
    localparam int RAD_W   = 16;
    localparam int POS_W   = 18;
    localparam int CRN_W   = 16;
    localparam int QW      = 30;
    localparam int TRIG_W  = 32;
    localparam int RND_W   = 34;
    localparam int T_W     = TRIG_BITS - 2;

    localparam int TRIG_LAT = 7;
    localparam int GEO_LAT  = 3;
    localparam int PIPE_D   = TRIG_BITS + TRIG_LAT + GEO_LAT;

    // 2*pi in Q30, scaled so that (t * TWO_PI_Q30) >> TRIG_BITS gives radians
    localparam logic [33:0] TWO_PI_Q30 = 34'd6746518852;
    localparam logic [QW:0] Q30_ONE    = 31'(64'd1 << QW);

    // reciprocal multipliers for exact floor division of values below 2^30
    localparam logic [30:0] RCP_6    = 31'd1431655766;
    localparam int          RSH_6    = 33;
    localparam logic [30:0] RCP_24   = 31'd1431655766;
    localparam int          RSH_24   = 35;
    localparam logic [30:0] RCP_120  = 31'd1145324613;
    localparam int          RSH_120  = 37;
    localparam logic [30:0] RCP_720  = 31'd1527099484;
    localparam int          RSH_720  = 40;

    localparam logic signed [RND_W-1:0] POS_HI = RND_W'(131071);
    localparam logic signed [RND_W-1:0] POS_LO = -RND_W'(131072);

    typedef enum logic [1:0] {
        REG_MAJOR = 2'd0,
        REG_MINOR = 2'd1,
        REG_RING  = 2'd2,
        REG_TUBE  = 2'd3
    } reg_addr_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [TRIG_BITS-1:0] dlow;
        logic [TRIG_BITS-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic             err;
        logic [CRN_W-1:0] here;
        logic [CRN_W-1:0] next_cross;
        logic [CRN_W-1:0] next_ring;
        logic [CRN_W-1:0] diag;
    } side_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
            r = CNT_W'(1);
        else if (v > CNT_W'(MAX_SEGMENTS))
            r = CNT_W'(MAX_SEGMENTS);
        return r;
    endfunction

    // divide by 2^30, half away from zero
    function automatic logic signed [RND_W-1:0] rnd30(input logic signed [63:0] v);
        logic [63:0]      mag;
        logic [63:0]      sum;
        logic [RND_W-1:0] r;
        mag = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        sum = (mag + (64'd1 << 29)) >> 30;
        r   = sum[RND_W-1:0];
        return v[63] ? $signed(RND_W'(0) - r) : $signed(r);
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] v);
        logic [POS_W-1:0] r;
        r = v[POS_W-1:0];
        if (v > POS_HI)
            r = POS_HI[POS_W-1:0];
        else if (v < POS_LO)
            r = POS_LO[POS_W-1:0];
        return r;
    endfunction

endpackage

// ===== src/tmcg_div_cell.sv =====
module tmcg_div_cell (
    input  logic                     clk,
    input  logic                     en,
    input  logic [tmcg_pkg::CNT_W-1:0] divisor,
    input  tmcg_pkg::div_lane_t      lane_in,
    output tmcg_pkg::div_lane_t      lane_out
);

    tmcg_pkg::div_lane_t lane_reg;
    tmcg_pkg::div_lane_t lane_next;
    logic [tmcg_pkg::CNT_W-1:0] trial;
    logic [tmcg_pkg::CNT_W-1:0] diff;
    logic                       take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {lane_in.rem, lane_in.dlow[tmcg_pkg::TRIG_BITS-1]};
        diff  = trial - divisor;
        take  = (trial >= divisor);
        lane_next.rem  = take ? diff[tmcg_pkg::REM_W-1:0] : trial[tmcg_pkg::REM_W-1:0];
        lane_next.dlow = {lane_in.dlow[tmcg_pkg::TRIG_BITS-2:0], 1'b0};
        lane_next.quo  = {lane_in.quo[tmcg_pkg::TRIG_BITS-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== src/tmcg_trig.sv =====
module tmcg_trig (
    input  logic                                clk,
    input  logic                                en,
    input  logic [tmcg_pkg::TRIG_BITS-1:0]      phase,
    output logic signed [tmcg_pkg::TRIG_W-1:0]  sin_q30,
    output logic signed [tmcg_pkg::TRIG_W-1:0]  cos_q30
);

    localparam int TB = tmcg_pkg::TRIG_BITS;
    localparam int TW = tmcg_pkg::T_W;
    localparam int QW = tmcg_pkg::QW;
    localparam logic [TW:0]   QUARTER = (TW+1)'(1) << (TB - 2);
    localparam logic [TW-1:0] EIGHTH  = TW'(1) << (TB - 3);

    // fold
    logic [TW-1:0]   prem;
    logic [TW:0]     tdiff;
    logic [TW-1:0]   t_next;
    logic            swap_next;
    logic [TW-1:0]   t_reg;
    tmcg_pkg::quad_t quad_reg [0:5];
    logic            swap_reg [0:5];

    // power series stages
    logic [TW+33:0]  xprod;
    logic [QW-1:0]   x1_reg;
    logic [59:0]     p_x2;
    logic [QW-1:0]   x2_reg, x2_x_reg;
    logic [59:0]     p_x3, p_x4;
    logic [QW-1:0]   x3_reg, x4_reg, x3_x_reg, x3_x2_reg;
    logic [59:0]     p_x5, p_x6;
    logic [QW-1:0]   x5_reg, x6_reg, x4_x_reg, x4_x2_reg, x4_x3_reg, x4_x4_reg;
    logic [63:0]     p_d3, p_d4, p_d5, p_d6;
    logic [QW-1:0]   d3_reg, d4_reg, d5_reg, d6_reg, x5_x_reg, h2_reg;
    logic [QW:0]     so, co, s_oct, c_oct;
    logic signed [tmcg_pkg::TRIG_W-1:0] ss, cs;
    logic signed [tmcg_pkg::TRIG_W-1:0] sin_next, cos_next;
    logic signed [tmcg_pkg::TRIG_W-1:0] sin_reg, cos_reg;

    always_comb
    begin
        prem  = phase[TB-3:0];
        tdiff = QUARTER - {1'b0, prem};
        if (prem <= EIGHTH)
        begin
            t_next    = prem;
            swap_next = 1'b0;
        end
        else
        begin
            t_next    = tdiff[TW-1:0];
            swap_next = 1'b1;
        end
    end

    always_comb
    begin
        xprod = (TW+34)'(t_reg) * (TW+34)'(tmcg_pkg::TWO_PI_Q30);
        p_x2  = 60'(x1_reg) * 60'(x1_reg);
        p_x3  = 60'(x2_reg) * 60'(x2_x_reg);
        p_x4  = 60'(x2_reg) * 60'(x2_reg);
        p_x5  = 60'(x4_reg) * 60'(x3_x_reg);
        p_x6  = 60'(x4_reg) * 60'(x3_x2_reg);
        p_d3  = 64'(x4_x3_reg) * 64'(tmcg_pkg::RCP_6);
        p_d4  = 64'(x4_x4_reg) * 64'(tmcg_pkg::RCP_24);
        p_d5  = 64'(x5_reg) * 64'(tmcg_pkg::RCP_120);
        p_d6  = 64'(x6_reg) * 64'(tmcg_pkg::RCP_720);
    end

    always_comb
    begin
        so = (QW+1)'(x5_x_reg) - (QW+1)'(d3_reg) + (QW+1)'(d5_reg);
        co = tmcg_pkg::Q30_ONE - (QW+1)'(h2_reg) + (QW+1)'(d4_reg) - (QW+1)'(d6_reg);
        s_oct = swap_reg[5] ? co : so;
        c_oct = swap_reg[5] ? so : co;
        ss = $signed({1'b0, s_oct});
        cs = $signed({1'b0, c_oct});
        case (quad_reg[5])
            tmcg_pkg::QUAD_0:
            begin
                sin_next = ss;
                cos_next = cs;
            end
            tmcg_pkg::QUAD_1:
            begin
                sin_next = cs;
                cos_next = -ss;
            end
            tmcg_pkg::QUAD_2:
            begin
                sin_next = -ss;
                cos_next = -cs;
            end
            default:
            begin
                sin_next = -cs;
                cos_next = ss;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg       <= t_next;
            quad_reg[0] <= tmcg_pkg::quad_t'(phase[TB-1:TB-2]);
            swap_reg[0] <= swap_next;
            for (int k = 1; k < 6; k++)
            begin
                quad_reg[k] <= quad_reg[k-1];
                swap_reg[k] <= swap_reg[k-1];
            end
            x1_reg    <= xprod[TB +: QW];
            x2_reg    <= p_x2[59:30];
            x2_x_reg  <= x1_reg;
            x3_reg    <= p_x3[59:30];
            x4_reg    <= p_x4[59:30];
            x3_x_reg  <= x2_x_reg;
            x3_x2_reg <= x2_reg;
            x5_reg    <= p_x5[59:30];
            x6_reg    <= p_x6[59:30];
            x4_x_reg  <= x3_x_reg;
            x4_x2_reg <= x3_x2_reg;
            x4_x3_reg <= x3_reg;
            x4_x4_reg <= x4_reg;
            d3_reg    <= QW'(p_d3 >> tmcg_pkg::RSH_6);
            d4_reg    <= QW'(p_d4 >> tmcg_pkg::RSH_24);
            d5_reg    <= QW'(p_d5 >> tmcg_pkg::RSH_120);
            d6_reg    <= QW'(p_d6 >> tmcg_pkg::RSH_720);
            x5_x_reg  <= x4_x_reg;
            h2_reg    <= x4_x2_reg >> 1;
            sin_reg   <= sin_next;
            cos_reg   <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

// ===== src/torus_mesh_cell_generator_unit.sv =====
// Torus mesh cell generator: one vertex and one quad of corner indices per item.
// Pipeline from input accept to m_tvalid: 16-cell phase divider chain,
// 7-stage sine/cosine series, 3 geometry stages, output register.
// Throughput: one item per cycle; the whole pipeline holds while the output item
// is stalled. Reset clears all valid bits and loads the default radii and counts.
module torus_mesh_cell_generator_unit (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // segment_index[7:0], cross_index[15:8]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // pos_x[17:0], pos_y[35:18], pos_z[53:36],
                                    // corner_here[69:54], corner_next_cross[85:70],
                                    // corner_next_ring[101:86], corner_diagonal[117:102]
    output logic         m_tuser    // index_error[0]
);

    localparam int TB = tmcg_pkg::TRIG_BITS;
    localparam int D  = tmcg_pkg::PIPE_D;
    localparam int CW = tmcg_pkg::CNT_W;

    logic [tmcg_pkg::RAD_W-1:0] major_reg, minor_reg;
    logic [CW-1:0]              ring_reg, tube_reg;
    logic [CW-1:0]              ns, nt;

    logic adv;
    logic cfg_wr;
    logic vld_reg [0:D-1];
    logic m_tvalid_reg;

    // entry
    logic [tmcg_pkg::IDX_W-1:0] in_i, in_j;
    logic [16:0]   row, base, here, nxc, nxr, dg;
    logic [CW-1:0] i_inc, j_inc, j_nxt;
    tmcg_pkg::side_t side_next;
    tmcg_pkg::side_t side_reg [0:D-1];

    tmcg_pkg::div_lane_t ring_init, tube_init;
    tmcg_pkg::div_lane_t ring_in [0:TB-1];
    tmcg_pkg::div_lane_t tube_in [0:TB-1];
    tmcg_pkg::div_lane_t ring_lane [0:TB-1];
    tmcg_pkg::div_lane_t tube_lane [0:TB-1];

    logic signed [tmcg_pkg::TRIG_W-1:0] sa, ca, sb, cb;

    // geometry
    logic signed [48:0] rc_next, rs_next;
    logic signed [48:0] g1_rc_reg, g1_rs_reg;
    logic signed [tmcg_pkg::TRIG_W-1:0] g1_ca_reg, g1_sa_reg, g2_ca_reg, g2_sa_reg;
    logic signed [tmcg_pkg::RND_W-1:0]  w_full, z_full;
    logic signed [19:0] g2_w_reg;
    logic signed [tmcg_pkg::RND_W-1:0]  g2_z_reg, g3_z_reg;
    logic signed [51:0] px_next, py_next, g3_px_reg, g3_py_reg;

    logic [tmcg_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic [119:0] m_tdata_reg;
    logic         m_tuser_reg;

    assign ns = tmcg_pkg::eff_count(ring_reg);
    assign nt = tmcg_pkg::eff_count(tube_reg);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= 16'd256;
            minor_reg <= 16'd64;
            ring_reg  <= 9'd32;
            tube_reg  <= 9'd16;
        end
        else if (cfg_wr)
        begin
            case (tmcg_pkg::reg_addr_t'(paddr[3:2]))
                tmcg_pkg::REG_MAJOR: major_reg <= pwdata[15:0];
                tmcg_pkg::REG_MINOR: minor_reg <= pwdata[15:0];
                tmcg_pkg::REG_RING:  ring_reg  <= pwdata[8:0];
                tmcg_pkg::REG_TUBE:  tube_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (tmcg_pkg::reg_addr_t'(paddr[3:2]))
            tmcg_pkg::REG_MAJOR: prdata = {16'd0, major_reg};
            tmcg_pkg::REG_MINOR: prdata = {16'd0, minor_reg};
            tmcg_pkg::REG_RING:  prdata = {23'd0, ring_reg};
            tmcg_pkg::REG_TUBE:  prdata = {23'd0, tube_reg};
            default:             prdata = '0;
        endcase
    end

    // flow control: every stage advances when the output register is free
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < D; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < D; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_tvalid_reg <= vld_reg[D-1];
        end
    end

    // corner indices and range check
    always_comb
    begin
        in_i  = s_tdata[7:0];
        in_j  = s_tdata[15:8];
        row   = 17'(in_i) * 17'(nt);
        i_inc = {1'b0, in_i} + 9'd1;
        j_inc = {1'b0, in_j} + 9'd1;
        j_nxt = (j_inc == nt) ? '0 : j_inc;
        base  = (i_inc == ns) ? '0 : row + 17'(nt);
        here  = row + 17'(in_j);
        nxc   = row + 17'(j_nxt);
        nxr   = base + 17'(in_j);
        dg    = base + 17'(j_nxt);
        side_next.err        = ({1'b0, in_i} >= ns) || ({1'b0, in_j} >= nt);
        side_next.here       = here[15:0];
        side_next.next_cross = nxc[15:0];
        side_next.next_ring  = nxr[15:0];
        side_next.diag       = dg[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < D; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // phase = round(k * 2^TB / n), one quotient bit per cell
    always_comb
    begin
        ring_init.rem  = in_i;
        ring_init.dlow = TB'(ns >> 1);
        ring_init.quo  = '0;
        tube_init.rem  = in_j;
        tube_init.dlow = TB'(nt >> 1);
        tube_init.quo  = '0;
    end

    for (genvar g = 0; g < TB; g++)
    begin : g_div
        if (g == 0)
        begin : g_first
            assign ring_in[g] = ring_init;
            assign tube_in[g] = tube_init;
        end
        else
        begin : g_rest
            assign ring_in[g] = ring_lane[g-1];
            assign tube_in[g] = tube_lane[g-1];
        end

        tmcg_div_cell u_ring_cell (
            .clk      (clk),
            .en       (adv),
            .divisor  (ns),
            .lane_in  (ring_in[g]),
            .lane_out (ring_lane[g])
        );

        tmcg_div_cell u_tube_cell (
            .clk      (clk),
            .en       (adv),
            .divisor  (nt),
            .lane_in  (tube_in[g]),
            .lane_out (tube_lane[g])
        );
    end

    tmcg_trig u_trig_ring (
        .clk     (clk),
        .en      (adv),
        .phase   (ring_lane[TB-1].quo),
        .sin_q30 (sa),
        .cos_q30 (ca)
    );

    tmcg_trig u_trig_tube (
        .clk     (clk),
        .en      (adv),
        .phase   (tube_lane[TB-1].quo),
        .sin_q30 (sb),
        .cos_q30 (cb)
    );

    // geometry
    always_comb
    begin
        rc_next = $signed({1'b0, minor_reg}) * cb;
        rs_next = $signed({1'b0, minor_reg}) * sb;
        w_full  = tmcg_pkg::rnd30($signed(64'({major_reg, 30'd0})) + 64'(g1_rc_reg));
        z_full  = tmcg_pkg::rnd30(64'(g1_rs_reg));
        px_next = g2_w_reg * g2_ca_reg;
        py_next = g2_w_reg * g2_sa_reg;
        pos_x   = tmcg_pkg::sat_pos(tmcg_pkg::rnd30(64'(g3_px_reg)));
        pos_y   = tmcg_pkg::sat_pos(tmcg_pkg::rnd30(64'(g3_py_reg)));
        pos_z   = tmcg_pkg::sat_pos(g3_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_rc_reg <= rc_next;
            g1_rs_reg <= rs_next;
            g1_ca_reg <= ca;
            g1_sa_reg <= sa;
            g2_w_reg  <= w_full[19:0];
            g2_z_reg  <= z_full;
            g2_ca_reg <= g1_ca_reg;
            g2_sa_reg <= g1_sa_reg;
            g3_px_reg <= px_next;
            g3_py_reg <= py_next;
            g3_z_reg  <= g2_z_reg;
            if (side_reg[D-1].err)
            begin
                m_tdata_reg <= '0;
            end
            else
            begin
                m_tdata_reg <= {2'b00, side_reg[D-1].diag, side_reg[D-1].next_ring,
                                side_reg[D-1].next_cross, side_reg[D-1].here,
                                pos_z, pos_y, pos_x};
            end
            m_tuser_reg <= side_reg[D-1].err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error item carries nonzero data");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg[0]) && $stable(vld_reg[D-1]) && $stable(m_tdata_reg))
        else $error("pipeline moved while stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item not in first stage");

    a_cross_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && nt != 9'd1 |-> m_tdata[85:70] != m_tdata[69:54])
        else $error("next cross corner equals this corner");
`endif

endmodule
